// ----- sv/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FIELD_W = 16;
    localparam int NUM_W   = FIELD_W + 1;

    typedef enum logic [1:0] {
        PART_W = 2'd0,
        PART_X = 2'd1,
        PART_Y = 2'd2,
        PART_Z = 2'd3
    } t_part;

    typedef struct packed {
        logic signed [FIELD_W-1:0] m00;
        logic signed [FIELD_W-1:0] m01;
        logic signed [FIELD_W-1:0] m02;
        logic signed [FIELD_W-1:0] m10;
        logic signed [FIELD_W-1:0] m11;
        logic signed [FIELD_W-1:0] m12;
        logic signed [FIELD_W-1:0] m20;
        logic signed [FIELD_W-1:0] m21;
        logic signed [FIELD_W-1:0] m22;
    } t_rmq_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quat_w;
        logic signed [FIELD_W-1:0] quat_x;
        logic signed [FIELD_W-1:0] quat_y;
        logic signed [FIELD_W-1:0] quat_z;
        t_part                     major_part;
    } t_rmq_out;

endpackage

// ----- sv/rmq_chan_if.sv -----
// ----------------------------------------------------------------------------
// rmq_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rmq_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to unit quaternion by the largest trace sum, fixed point.
// Pipeline depth is set mostly by the square root and divider pipes.
// Throughput: one transaction per cycle; a stall at the output holds every stage.
// Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_chan_if.sink   i_in,
    rmq_chan_if.source o_out
);
    localparam int F      = FRAC_BITS;
    localparam int SW     = ((F > 17) ? F : 17) + 2;
    localparam int RAD_W  = SW + F + ((SW + F) % 2);
    localparam int QW     = RAD_W / 2;
    localparam int DW     = QW + 1;
    localparam int ST     = F + 2;
    localparam int NW     = F + 18;
    localparam int CW     = DW + ST + 1;
    localparam int MW     = (QW > ST) ? QW : ST;
    localparam int L      = QW + ST + 4;
    localparam int PCAP   = (F >= 15) ? 32767 : (1 << F);
    localparam int NCAP   = (F >= 15) ? 32768 : (1 << F);
    localparam logic signed [SW:0] ONE_S = (SW+1)'(1) << F;
    localparam logic [DW-1:0]      HALF  = DW'(1) << (F - 1);

    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en       = !r_vld[L-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // stage 1: trace sums and off-diagonal sums/differences
    logic signed [SW:0]      w_a00, w_a11, w_a22;
    logic signed [SW:0]      w_sum [4];
    logic [SW-1:0]           r_s1_sum [4];
    logic signed [NUM_W-1:0] r_s1_num [6];

    assign w_a00 = (SW+1)'(i_in.data.m00);
    assign w_a11 = (SW+1)'(i_in.data.m11);
    assign w_a22 = (SW+1)'(i_in.data.m22);
    assign w_sum[0] = ONE_S + w_a00 + w_a11 + w_a22;
    assign w_sum[1] = ONE_S + w_a00 - w_a11 - w_a22;
    assign w_sum[2] = ONE_S - w_a00 + w_a11 - w_a22;
    assign w_sum[3] = ONE_S - w_a00 - w_a11 + w_a22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r_s1_sum[k] <= w_sum[k][SW] ? '0 : w_sum[k][SW-1:0];
            end
            r_s1_num[0] <= NUM_W'(i_in.data.m21) - NUM_W'(i_in.data.m12);
            r_s1_num[1] <= NUM_W'(i_in.data.m02) - NUM_W'(i_in.data.m20);
            r_s1_num[2] <= NUM_W'(i_in.data.m10) - NUM_W'(i_in.data.m01);
            r_s1_num[3] <= NUM_W'(i_in.data.m10) + NUM_W'(i_in.data.m01);
            r_s1_num[4] <= NUM_W'(i_in.data.m02) + NUM_W'(i_in.data.m20);
            r_s1_num[5] <= NUM_W'(i_in.data.m21) + NUM_W'(i_in.data.m12);
        end
    end

    // stage 2: pick the major component and route minor numerators to lanes
    t_part                   w_sel;
    logic [SW-1:0]           w_s;
    logic signed [NUM_W-1:0] w_lane [3];
    t_part                   r_s2_sel;
    logic [SW-1:0]           r_s2_s;
    logic signed [NUM_W-1:0] r_s2_num [3];

    always_comb begin
        if (r_s1_sum[0] > r_s1_sum[1] && r_s1_sum[0] > r_s1_sum[2]
                && r_s1_sum[0] > r_s1_sum[3]) begin
            w_sel = PART_W;
        end else if (r_s1_sum[1] > r_s1_sum[2] && r_s1_sum[1] > r_s1_sum[3]) begin
            w_sel = PART_X;
        end else if (r_s1_sum[2] > r_s1_sum[3]) begin
            w_sel = PART_Y;
        end else begin
            w_sel = PART_Z;
        end
        w_s = r_s1_sum[w_sel];
        unique case (w_sel)
            PART_W: begin
                w_lane[0] = r_s1_num[0];
                w_lane[1] = r_s1_num[1];
                w_lane[2] = r_s1_num[2];
            end
            PART_X: begin
                w_lane[0] = r_s1_num[0];
                w_lane[1] = r_s1_num[3];
                w_lane[2] = r_s1_num[4];
            end
            PART_Y: begin
                w_lane[0] = r_s1_num[1];
                w_lane[1] = r_s1_num[3];
                w_lane[2] = r_s1_num[5];
            end
            default: begin
                w_lane[0] = r_s1_num[2];
                w_lane[1] = r_s1_num[4];
                w_lane[2] = r_s1_num[5];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sel <= w_sel;
            r_s2_s   <= w_s;
            r_s2_num <= w_lane;
        end
    end

    // square root pipe with side delay line
    logic [QW-1:0]           w_root;
    t_part                   r_sq_sel [QW];
    logic signed [NUM_W-1:0] r_sq_num [QW][3];

    rmq_sqrt #(.RAD_W(RAD_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (RAD_W'(r_s2_s) << F),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_sel[0] <= r_s2_sel;
            r_sq_num[0] <= r_s2_num;
            for (int k = 1; k < QW; k++) begin
                r_sq_sel[k] <= r_sq_sel[k-1];
                r_sq_num[k] <= r_sq_num[k-1];
            end
        end
    end

    // divisor, scaled dividends and overflow
    logic [DW-1:0]   w_d4;
    logic [DW-1:0]   w_den;
    logic [NW-1:0]   w_mag [3];
    logic [DW-1:0]   r_d_den;
    logic [QW-2:0]   r_d_major;
    t_part           r_d_sel;
    logic [NW-1:0]   r_d_num [3];
    logic [2:0]      r_d_neg;
    logic [2:0]      r_d_ovf;

    assign w_d4  = {w_root[QW-1:1], 2'b00};
    assign w_den = (w_d4 < HALF) ? HALF : w_d4;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = r_sq_num[QW-1][k][NUM_W-1]
                     ? NW'(-r_sq_num[QW-1][k]) : NW'(r_sq_num[QW-1][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_den   <= w_den;
            r_d_major <= w_root[QW-1:1];
            r_d_sel   <= r_sq_sel[QW-1];
            for (int k = 0; k < 3; k++) begin
                r_d_num[k] <= (w_mag[k] << F) + NW'(w_den >> 1);
                r_d_neg[k] <= r_sq_num[QW-1][k][NUM_W-1];
                r_d_ovf[k] <= CW'((w_mag[k] << F) + NW'(w_den >> 1))
                              >= (CW'(w_den) << ST);
            end
        end
    end

    // divider lanes with side delay line
    logic [ST-1:0] w_quo [3];
    t_part         r_dv_sel   [ST];
    logic [QW-2:0] r_dv_major [ST];
    logic [2:0]    r_dv_neg   [ST];
    logic [2:0]    r_dv_ovf   [ST];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        rmq_div #(.QUO_W(ST), .NUM_W(NW), .DEN_W(DW)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_d_num[g]),
            .i_den (r_d_den),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_sel[0]   <= r_d_sel;
            r_dv_major[0] <= r_d_major;
            r_dv_neg[0]   <= r_d_neg;
            r_dv_ovf[0]   <= r_d_ovf;
            for (int k = 1; k < ST; k++) begin
                r_dv_sel[k]   <= r_dv_sel[k-1];
                r_dv_major[k] <= r_dv_major[k-1];
                r_dv_neg[k]   <= r_dv_neg[k-1];
                r_dv_ovf[k]   <= r_dv_ovf[k-1];
            end
        end
    end

    // saturate, sign and reassemble
    function automatic logic [FIELD_W-1:0] fn_sat(
        input logic          neg,
        input logic          ovf,
        input logic [MW-1:0] mag
    );
        logic [MW-1:0]    cap;
        logic [MW-1:0]    lim;
        logic [FIELD_W:0] val;
        cap = neg ? MW'(NCAP) : MW'(PCAP);
        lim = (ovf || mag > cap) ? cap : mag;
        val = (FIELD_W+1)'(lim);
        if (neg) begin
            val = -val;
        end
        return val[FIELD_W-1:0];
    endfunction

    logic [FIELD_W-1:0] w_maj;
    logic [FIELD_W-1:0] w_min [3];
    t_rmq_out           w_out;
    t_rmq_out           r_out;

    always_comb begin
        w_maj = fn_sat(1'b0, 1'b0, MW'(r_dv_major[ST-1]));
        for (int k = 0; k < 3; k++) begin
            w_min[k] = fn_sat(r_dv_neg[ST-1][k], r_dv_ovf[ST-1][k], MW'(w_quo[k]));
        end
        w_out.major_part = r_dv_sel[ST-1];
        unique case (r_dv_sel[ST-1])
            PART_W: begin
                w_out.quat_w = w_maj;
                w_out.quat_x = w_min[0];
                w_out.quat_y = w_min[1];
                w_out.quat_z = w_min[2];
            end
            PART_X: begin
                w_out.quat_w = w_min[0];
                w_out.quat_x = w_maj;
                w_out.quat_y = w_min[1];
                w_out.quat_z = w_min[2];
            end
            PART_Y: begin
                w_out.quat_w = w_min[0];
                w_out.quat_x = w_min[1];
                w_out.quat_y = w_maj;
                w_out.quat_z = w_min[2];
            end
            default: begin
                w_out.quat_w = w_min[0];
                w_out.quat_x = w_min[1];
                w_out.quat_y = w_min[2];
                w_out.quat_z = w_maj;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_out;
        end
    end

    assign o_out.valid = r_vld[L-1];
    assign o_out.data  = r_out;
endmodule

// ----- sv/rmq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_W-1:0]     i_rad,
    output logic [RAD_W/2-1:0]   o_root
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        logic [REM_W-1:0]  w_rem_prev;
        logic [ROOT_W-1:0] w_root_prev;
        logic [RAD_W-1:0]  w_rad_prev;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem_prev  = '0;
            assign w_root_prev = '0;
            assign w_rad_prev  = i_rad;
        end else begin : g_next
            assign w_rem_prev  = r_rem[j-1];
            assign w_root_prev = r_root[j-1];
            assign w_rad_prev  = r_rad[j-1];
        end

        assign w_cur   = {w_rem_prev[REM_W-3:0], w_rad_prev[RAD_W-1 -: 2]};
        assign w_trial = {w_root_prev, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[j] <= {w_root_prev[ROOT_W-2:0], w_ge};
                r_rad[j]  <= w_rad_prev << 2;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
endmodule

// ----- sv/rmq_div.sv -----
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int QUO_W = 16,
    parameter int NUM_W = 32,
    parameter int DEN_W = 18
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic [QUO_W-1:0]   o_quo
);
    localparam int CMP_W = DEN_W + QUO_W + 1;

    logic [CMP_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [CMP_W-1:0] w_rem_prev;
        logic [QUO_W-1:0] w_quo_prev;
        logic [DEN_W-1:0] w_den_prev;
        logic [CMP_W-1:0] w_sub;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_prev = CMP_W'(i_num);
            assign w_quo_prev = '0;
            assign w_den_prev = i_den;
        end else begin : g_next
            assign w_rem_prev = r_rem[j-1];
            assign w_quo_prev = r_quo[j-1];
            assign w_den_prev = r_den[j-1];
        end

        assign w_sub = CMP_W'(w_den_prev) << (QUO_W - 1 - j);
        assign w_ge  = (w_rem_prev >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? (w_rem_prev - w_sub) : w_rem_prev;
                r_quo[j] <= {w_quo_prev[QUO_W-2:0], w_ge};
                r_den[j] <= w_den_prev;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];
endmodule
